FILE: hdl/ata_pio_sector_sequencer_macros.svh
// ----------------------------------------------------------------------------
// ATA PIO sector sequencer assertion macros
// Shared concurrent assertion forms for the sequencer checker.
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_SECTOR_SEQUENCER_MACROS_SVH
`define ATA_PIO_SECTOR_SEQUENCER_MACROS_SVH

// Checked outside reset.
`define ASPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/asps_pkg.sv
// ----------------------------------------------------------------------------
// asps_pkg
// Types, codes and constants for the ATA PIO LBA28 sector sequencer.
// ----------------------------------------------------------------------------
package asps_pkg;

  localparam int MAX_RES     = 7;
  localparam int CNT_W       = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 22;
  localparam int POLL_W      = 22;
  localparam int LBA_W       = 28;
  localparam int SCNT_W      = 9;

  localparam logic [POLL_W-1:0] POLL_LIMIT_RST = 22'd2000000;
  localparam logic [POLL_W-1:0] POLL_SAT       = '1;
  localparam logic [SCNT_W-1:0] SCNT_MAX       = 9'd256;
  localparam logic [7:0]        WORD_LAST      = 8'd255;
  localparam logic [7:0]        SETTLE_READS   = 8'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_PRESENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT    = 1'b1;

  // Input item codes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_STATUS = 2'd1;
  localparam logic [1:0] OP_DATA   = 2'd2;

  // Task file register indexes
  localparam logic [2:0] REG_NONE   = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd2;
  localparam logic [2:0] REG_LBA0   = 3'd3;
  localparam logic [2:0] REG_LBA1   = 3'd4;
  localparam logic [2:0] REG_LBA2   = 3'd5;
  localparam logic [2:0] REG_DEVICE = 3'd6;
  localparam logic [2:0] REG_CMD    = 3'd7;

  // Device and command bytes
  localparam logic [7:0] DEV_MASTER = 8'hA0;
  localparam logic [7:0] DEV_SLAVE  = 8'hB0;
  localparam logic [7:0] DEV_LBA    = 8'hE0;
  localparam logic [7:0] CMD_READ   = 8'h20;
  localparam logic [7:0] CMD_WRITE  = 8'h30;
  localparam logic [7:0] CMD_FLUSH  = 8'hE7;

  // Status bits
  localparam int ST_BSY  = 7;
  localparam int ST_DRDY = 6;
  localparam int ST_DRQ  = 3;
  localparam int ST_ERR  = 0;

  typedef enum logic [2:0] {
    ACT_WR_REG   = 3'd0,
    ACT_RD_ALT   = 3'd1,
    ACT_RD_STAT  = 3'd2,
    ACT_RD_DATA  = 3'd3,
    ACT_WR_DATA  = 3'd4,
    ACT_DELIVER  = 3'd5,
    ACT_DONE     = 3'd6,
    ACT_FAIL     = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    FAIL_NONE      = 3'd0,
    FAIL_ABSENT    = 3'd1,
    FAIL_BAD_COUNT = 3'd2,
    FAIL_READY_TO  = 3'd3,
    FAIL_DRQ_TO    = 3'd4,
    FAIL_DEV_ERR   = 3'd5,
    FAIL_BUSY      = 3'd6
  } fail_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETTLE = 3'd1,
    PH_READY  = 3'd2,
    PH_DRQ    = 3'd3,
    PH_XFER   = 3'd4,
    PH_FLUSH  = 3'd5
  } phase_t;

  typedef struct packed {
    action_t     action;
    logic [2:0]  reg_index;
    logic [15:0] value;
    fail_t       fail_code;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]   n;
  } burst_t;

  function automatic res_t mk_res(action_t act, logic [2:0] ri, logic [15:0] val,
                                  fail_t fc);
    res_t r;
    r.action    = act;
    r.reg_index = ri;
    r.value     = val;
    r.fail_code = fc;
    return r;
  endfunction

  function automatic res_t mk_wr(logic [2:0] ri, logic [7:0] b);
    return mk_res(ACT_WR_REG, ri, {8'h00, b}, FAIL_NONE);
  endfunction

  function automatic res_t mk_act(action_t act);
    return mk_res(act, REG_NONE, 16'h0000, FAIL_NONE);
  endfunction

endpackage

FILE: hdl/asps_core.sv
// ----------------------------------------------------------------------------
// asps_core
// Sequencer state, configuration registers and the per-item step logic that
// turns one accepted item into a burst of results.
// ----------------------------------------------------------------------------
module asps_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [asps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [asps_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               accept,
  input  logic [1:0]                         op,
  input  logic                               write_dir,
  input  logic                               drive,
  input  logic [asps_pkg::LBA_W-1:0]         lba,
  input  logic [asps_pkg::SCNT_W-1:0]        sector_count,
  input  logic [7:0]                         status_byte,
  input  logic [15:0]                        data_word,
  output asps_pkg::burst_t                   burst
);

  logic [1:0]                      drive_present;
  logic [asps_pkg::POLL_W-1:0]     poll_limit;

  asps_pkg::phase_t                phase, phase_next;
  logic                            cur_drive, cur_drive_next;
  logic                            cur_write, cur_write_next;
  logic [asps_pkg::SCNT_W-1:0]     sectors_left, sectors_left_next;
  logic [7:0]                      word_index, word_index_next;
  logic [asps_pkg::POLL_W-1:0]     poll_count, poll_count_next;
  logic [asps_pkg::LBA_W-1:0]      saved_lba, saved_lba_next;
  logic [asps_pkg::SCNT_W-1:0]     saved_count, saved_count_next;

  logic [asps_pkg::POLL_W-1:0]     pc_inc;
  logic [asps_pkg::POLL_W-1:0]     lim;
  logic                            exhausted;
  logic [7:0]                      wi_inc;
  logic [asps_pkg::SCNT_W-1:0]     sl_dec;
  logic [7:0]                      dev_byte;

  always_comb begin
    pc_inc    = (poll_count < asps_pkg::POLL_SAT) ? poll_count + 1'b1 : poll_count;
    lim       = (poll_limit == '0) ? asps_pkg::POLL_W'(1) : poll_limit;
    exhausted = pc_inc >= lim;
    wi_inc    = word_index + 8'd1;
    sl_dec    = (sectors_left != '0) ? sectors_left - 1'b1 : sectors_left;
    dev_byte  = asps_pkg::DEV_LBA | {3'b000, cur_drive, saved_lba[27:24]};
  end

  always_comb begin
    burst             = '0;
    phase_next        = phase;
    cur_drive_next    = cur_drive;
    cur_write_next    = cur_write;
    sectors_left_next = sectors_left;
    word_index_next   = word_index;
    poll_count_next   = poll_count;
    saved_lba_next    = saved_lba;
    saved_count_next  = saved_count;

    if (op == asps_pkg::OP_START && phase == asps_pkg::PH_IDLE) begin
      if (!drive_present[drive]) begin
        burst.res[0] = asps_pkg::mk_res(asps_pkg::ACT_FAIL, asps_pkg::REG_NONE, 16'h0000,
                                        asps_pkg::FAIL_ABSENT);
        burst.n      = 3'd1;
      end else if (sector_count == '0 || sector_count > asps_pkg::SCNT_MAX) begin
        burst.res[0] = asps_pkg::mk_res(asps_pkg::ACT_FAIL, asps_pkg::REG_NONE, 16'h0000,
                                        asps_pkg::FAIL_BAD_COUNT);
        burst.n      = 3'd1;
      end else begin
        cur_drive_next    = drive;
        cur_write_next    = write_dir;
        saved_lba_next    = lba;
        saved_count_next  = sector_count;
        sectors_left_next = sector_count;
        word_index_next   = '0;
        poll_count_next   = '0;
        burst.res[0]      = asps_pkg::mk_wr(asps_pkg::REG_DEVICE,
                                            drive ? asps_pkg::DEV_SLAVE
                                                  : asps_pkg::DEV_MASTER);
        burst.res[1]      = asps_pkg::mk_act(asps_pkg::ACT_RD_ALT);
        burst.n           = 3'd2;
        phase_next        = asps_pkg::PH_SETTLE;
      end
    end else if (op == asps_pkg::OP_STATUS && phase == asps_pkg::PH_SETTLE) begin
      // settle reads: the returned byte is dropped
      word_index_next = wi_inc;
      burst.res[0]    = asps_pkg::mk_act(asps_pkg::ACT_RD_ALT);
      burst.n         = 3'd1;
      if (wi_inc >= asps_pkg::SETTLE_READS) begin
        word_index_next = '0;
        poll_count_next = '0;
        phase_next      = asps_pkg::PH_READY;
      end
    end else if (op == asps_pkg::OP_STATUS && phase == asps_pkg::PH_READY) begin
      poll_count_next = pc_inc;
      if (!status_byte[asps_pkg::ST_BSY] && status_byte[asps_pkg::ST_DRDY]) begin
        burst.res[0]    = asps_pkg::mk_wr(asps_pkg::REG_DEVICE, dev_byte);
        burst.res[1]    = asps_pkg::mk_wr(asps_pkg::REG_COUNT, saved_count[7:0]);
        burst.res[2]    = asps_pkg::mk_wr(asps_pkg::REG_LBA0, saved_lba[7:0]);
        burst.res[3]    = asps_pkg::mk_wr(asps_pkg::REG_LBA1, saved_lba[15:8]);
        burst.res[4]    = asps_pkg::mk_wr(asps_pkg::REG_LBA2, saved_lba[23:16]);
        burst.res[5]    = asps_pkg::mk_wr(asps_pkg::REG_CMD,
                                          cur_write ? asps_pkg::CMD_WRITE
                                                    : asps_pkg::CMD_READ);
        burst.res[6]    = asps_pkg::mk_act(asps_pkg::ACT_RD_STAT);
        burst.n         = 3'd7;
        poll_count_next = '0;
        phase_next      = asps_pkg::PH_DRQ;
      end else if (exhausted) begin
        burst.res[0] = asps_pkg::mk_res(asps_pkg::ACT_FAIL, asps_pkg::REG_NONE, 16'h0000,
                                        asps_pkg::FAIL_READY_TO);
        burst.n      = 3'd1;
        phase_next   = asps_pkg::PH_IDLE;
      end else begin
        burst.res[0] = asps_pkg::mk_act(asps_pkg::ACT_RD_ALT);
        burst.n      = 3'd1;
      end
    end else if (op == asps_pkg::OP_STATUS && phase == asps_pkg::PH_DRQ) begin
      poll_count_next = pc_inc;
      if (status_byte[asps_pkg::ST_DRQ]) begin
        word_index_next = '0;
        phase_next      = asps_pkg::PH_XFER;
        if (!cur_write) begin
          burst.res[0] = asps_pkg::mk_act(asps_pkg::ACT_RD_DATA);
          burst.n      = 3'd1;
        end
      end else if (status_byte[asps_pkg::ST_ERR]) begin
        burst.res[0] = asps_pkg::mk_res(asps_pkg::ACT_FAIL, asps_pkg::REG_NONE, 16'h0000,
                                        asps_pkg::FAIL_DEV_ERR);
        burst.n      = 3'd1;
        phase_next   = asps_pkg::PH_IDLE;
      end else if (exhausted) begin
        burst.res[0] = asps_pkg::mk_res(asps_pkg::ACT_FAIL, asps_pkg::REG_NONE, 16'h0000,
                                        asps_pkg::FAIL_DRQ_TO);
        burst.n      = 3'd1;
        phase_next   = asps_pkg::PH_IDLE;
      end else begin
        burst.res[0] = asps_pkg::mk_act(asps_pkg::ACT_RD_STAT);
        burst.n      = 3'd1;
      end
    end else if (op == asps_pkg::OP_DATA && phase == asps_pkg::PH_XFER) begin
      burst.res[0]    = asps_pkg::mk_res(cur_write ? asps_pkg::ACT_WR_DATA
                                                   : asps_pkg::ACT_DELIVER,
                                         asps_pkg::REG_NONE, data_word,
                                         asps_pkg::FAIL_NONE);
      word_index_next = wi_inc;
      if (word_index >= asps_pkg::WORD_LAST) begin
        word_index_next   = '0;
        sectors_left_next = sl_dec;
        if (sl_dec != '0) begin
          burst.res[1]    = asps_pkg::mk_act(asps_pkg::ACT_RD_STAT);
          burst.n         = 3'd2;
          poll_count_next = '0;
          phase_next      = asps_pkg::PH_DRQ;
        end else if (cur_write) begin
          burst.res[1]    = asps_pkg::mk_wr(asps_pkg::REG_CMD, asps_pkg::CMD_FLUSH);
          burst.res[2]    = asps_pkg::mk_act(asps_pkg::ACT_RD_ALT);
          burst.n         = 3'd3;
          poll_count_next = '0;
          phase_next      = asps_pkg::PH_FLUSH;
        end else begin
          burst.res[1] = asps_pkg::mk_act(asps_pkg::ACT_DONE);
          burst.n      = 3'd2;
          phase_next   = asps_pkg::PH_IDLE;
        end
      end else if (!cur_write) begin
        burst.res[1] = asps_pkg::mk_act(asps_pkg::ACT_RD_DATA);
        burst.n      = 3'd2;
      end else begin
        burst.n = 3'd1;
      end
    end else if (op == asps_pkg::OP_STATUS && phase == asps_pkg::PH_FLUSH) begin
      poll_count_next = pc_inc;
      if (!status_byte[asps_pkg::ST_BSY]) begin
        burst.res[0] = asps_pkg::mk_act(asps_pkg::ACT_DONE);
        burst.n      = 3'd1;
        phase_next   = asps_pkg::PH_IDLE;
      end else if (exhausted) begin
        burst.res[0] = asps_pkg::mk_res(asps_pkg::ACT_FAIL, asps_pkg::REG_NONE, 16'h0000,
                                        asps_pkg::FAIL_BUSY);
        burst.n      = 3'd1;
        phase_next   = asps_pkg::PH_IDLE;
      end else begin
        burst.res[0] = asps_pkg::mk_act(asps_pkg::ACT_RD_ALT);
        burst.n      = 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_present <= '0;
      poll_limit    <= asps_pkg::POLL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        asps_pkg::CFG_DRIVE_PRESENT: drive_present <= cfg_data[1:0];
        asps_pkg::CFG_POLL_LIMIT:    poll_limit    <= cfg_data[asps_pkg::POLL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= asps_pkg::PH_IDLE;
      cur_drive    <= 1'b0;
      cur_write    <= 1'b0;
      sectors_left <= '0;
      word_index   <= '0;
      poll_count   <= '0;
      saved_lba    <= '0;
      saved_count  <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      cur_drive    <= cur_drive_next;
      cur_write    <= cur_write_next;
      sectors_left <= sectors_left_next;
      word_index   <= word_index_next;
      poll_count   <= poll_count_next;
      saved_lba    <= saved_lba_next;
      saved_count  <= saved_count_next;
    end
  end

endmodule

FILE: hdl/asps_expander.sv
// ----------------------------------------------------------------------------
// asps_expander
// Result register: holds one burst and hands its results out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module asps_expander (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  asps_pkg::burst_t    burst,
  output logic                load_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output asps_pkg::res_t      res,
  output logic                last
);

  asps_pkg::res_t [asps_pkg::MAX_RES-1:0] res_q;
  logic [asps_pkg::CNT_W-1:0]             cnt;
  logic [asps_pkg::CNT_W-1:0]             ptr;

  always_comb begin
    out_valid = ptr != cnt;
    last      = ptr == cnt - 1'b1;
    res       = res_q[ptr];
    // take a new burst when empty, or once the final pending result leaves this cycle
    load_ok   = !out_valid || (out_ready && last);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= burst.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ptr <= '0;
    end else if (load) begin
      cnt <= burst.n;
      ptr <= '0;
    end else if (out_valid && out_ready) begin
      ptr <= ptr + 1'b1;
    end
  end

endmodule

FILE: hdl/ata_pio_sector_sequencer.sv
// Latency: the first result of an item appears the cycle after it is accepted.
// Throughput: an item's results leave the result register one per cycle while out_ready
//   is high; the next item is taken in the cycle the last of them transfers, so items
//   with one result (or none) go at one per cycle when the output does not stall.
// Reset: synchronous; clears phase, counters and saved request, drive_present
//   to 0 and poll_limit to 2000000, and empties the result register.
// ----------------------------------------------------------------------------
// ata_pio_sector_sequencer
// Host-side ATA PIO LBA28 read/write sequencer top level.
// ----------------------------------------------------------------------------
module ata_pio_sector_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [asps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [asps_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       op,
  input  logic                             write_dir,
  input  logic                             drive,
  input  logic [asps_pkg::LBA_W-1:0]       lba,
  input  logic [asps_pkg::SCNT_W-1:0]      sector_count,
  input  logic [7:0]                       status_byte,
  input  logic [15:0]                      data_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       action,
  output logic [2:0]                       reg_index,
  output logic [15:0]                      value,
  output logic [2:0]                       fail_code,
  output logic                             last
);

  asps_pkg::burst_t burst;
  asps_pkg::res_t   res;
  logic             accept;
  logic             load_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = load_ok;
  assign accept    = in_valid && load_ok;

  asps_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .op           (op),
    .write_dir    (write_dir),
    .drive        (drive),
    .lba          (lba),
    .sector_count (sector_count),
    .status_byte  (status_byte),
    .data_word    (data_word),
    .burst        (burst)
  );

  asps_expander u_exp (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .burst     (burst),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res),
    .last      (last)
  );

  assign action    = res.action;
  assign reg_index = res.reg_index;
  assign value     = res.value;
  assign fail_code = res.fail_code;

endmodule

FILE: hdl/asps_checker.sv
// ----------------------------------------------------------------------------
// asps_checker
// Port-level checks on the sequencer's result channel.
// ----------------------------------------------------------------------------
`include "ata_pio_sector_sequencer_macros.svh"

module asps_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  action,
  input logic [2:0]  fail_code,
  input logic        last
);

  `ASPS_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result pending after reset")
  `ASPS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(action) && $stable(last), "result changed while stalled")
  `ASPS_ASSERT(a_fail_code, out_valid |-> ((action == asps_pkg::ACT_FAIL) == (fail_code != asps_pkg::FAIL_NONE)), "fail code does not match action")
  `ASPS_ASSERT(a_end_last, out_valid && (action == asps_pkg::ACT_DONE || action == asps_pkg::ACT_FAIL) |-> last, "done or fail not last of its burst")
  `ASPS_ASSERT(a_no_early_ready, out_valid && !last |-> !in_ready, "new item taken mid-burst")

endmodule

bind ata_pio_sector_sequencer asps_checker u_asps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .action    (action),
  .fail_code (fail_code),
  .last      (last)
);

FILE: bench/tb_ata_pio_sector_sequencer.sv
// ----------------------------------------------------------------------------
// tb_ata_pio_sector_sequencer
// Self-checking bench for the ATA PIO LBA28 sector sequencer. A directed table
// covers request checks, settle reads, the poll limits and the DRQ/ERR order.
// Random drive-side traffic follows the engine phase, with small doses of
// noise, so that most requests reach the data transfer and the cache flush.
// Results are checked against an in-bench model or the table's failure code.
// ----------------------------------------------------------------------------
module tb_ata_pio_sector_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         RUN_LIMIT   = 1500000;
  localparam int         DRAIN_PAD   = 8;
  localparam int         HOLD_CYCLES = 300;
  localparam int         HOLD_AFTER  = 200;
  localparam int         PAUSE_AFTER = 150;
  localparam int         RAND_ITEMS  = 250;
  localparam int         ITEM_CAP    = 8000;

  typedef struct packed {
    logic [1:0]                  op;
    logic                        write_dir;
    logic                        drive;
    logic [asps_pkg::LBA_W-1:0]  lba;
    logic [asps_pkg::SCNT_W-1:0] sector_count;
    logic [7:0]                  status_byte;
    logic [15:0]                 data_word;
  } bus_item_t;

  typedef struct packed {
    asps_pkg::action_t action;
    logic [2:0]        reg_index;
    logic [15:0]       value;
    asps_pkg::fail_t   fail_code;
    logic              last;
  } seq_result_t;

  typedef struct {
    asps_pkg::phase_t            phase;
    logic                        cur_drive;
    logic                        cur_write;
    logic [asps_pkg::SCNT_W-1:0] sectors_left;
    logic [7:0]                  word_index;
    logic [asps_pkg::POLL_W-1:0] poll_count;
    logic [asps_pkg::LBA_W-1:0]  saved_lba;
    logic [asps_pkg::SCNT_W-1:0] saved_count;
  } engine_state_t;

  typedef enum {ROW_PREDICT, ROW_IGNORED, ROW_FAILS, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    bus_item_t                       item;
    asps_pkg::fail_t                 code;
    logic [asps_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [asps_pkg::CFG_DATA_W-1:0] cfg_val;
  } dir_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [asps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [asps_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [1:0]                      op = '0;
  logic                            write_dir = 1'b0;
  logic                            drive = 1'b0;
  logic [asps_pkg::LBA_W-1:0]      lba = '0;
  logic [asps_pkg::SCNT_W-1:0]     sector_count = '0;
  logic [7:0]                      status_byte = '0;
  logic [15:0]                     data_word = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [2:0]                      action;
  logic [2:0]                      reg_index;
  logic [15:0]                     value;
  logic [2:0]                      fail_code;
  logic                            last;

  ata_pio_sector_sequencer u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .write_dir    (write_dir),
    .drive        (drive),
    .lba          (lba),
    .sector_count (sector_count),
    .status_byte  (status_byte),
    .data_word    (data_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .action       (action),
    .reg_index    (reg_index),
    .value        (value),
    .fail_code    (fail_code),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Engine model and its copy of the registers
  engine_state_t               eng;
  logic [1:0]                  present_m;
  logic [asps_pkg::POLL_W-1:0] poll_lim_m;
  seq_result_t                 step_res[$];
  seq_result_t                 pending_res[$];

  int err_count    = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int done_pred    = 0;
  int fails_pred   = 0;
  int cycles       = 0;
  int tx_run_left  = 0;
  int rx_run_left  = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void note(asps_pkg::action_t a, logic [2:0] ri, logic [15:0] v,
                               asps_pkg::fail_t fc);
    seq_result_t r;
    r.action    = a;
    r.reg_index = ri;
    r.value     = v;
    r.fail_code = fc;
    r.last      = 1'b0;
    step_res.push_back(r);
    if (a == asps_pkg::ACT_DONE) done_pred++;
    if (a == asps_pkg::ACT_FAIL) fails_pred++;
  endfunction

  function automatic void note_reg(logic [2:0] ri, logic [7:0] b);
    note(asps_pkg::ACT_WR_REG, ri, {8'h00, b}, asps_pkg::FAIL_NONE);
  endfunction

  function automatic void note_act(asps_pkg::action_t a);
    note(a, asps_pkg::REG_NONE, 16'h0000, asps_pkg::FAIL_NONE);
  endfunction

  function automatic void abort(asps_pkg::fail_t fc);
    note(asps_pkg::ACT_FAIL, asps_pkg::REG_NONE, 16'h0000, fc);
    eng.phase = asps_pkg::PH_IDLE;
  endfunction

  function automatic void bump_poll();
    if (eng.poll_count != asps_pkg::POLL_SAT) eng.poll_count = eng.poll_count + 1'b1;
  endfunction

  function automatic bit polls_used_up();
    logic [asps_pkg::POLL_W-1:0] lim;
    lim = (poll_lim_m == '0) ? asps_pkg::POLL_W'(1) : poll_lim_m;
    return eng.poll_count >= lim;
  endfunction

  function automatic void open_drq_wait();
    eng.poll_count = '0;
    eng.phase = asps_pkg::PH_DRQ;
    note_act(asps_pkg::ACT_RD_STAT);
  endfunction

  // Work out the results one accepted item causes and advance the model
  function automatic void advance_engine(bus_item_t it);
    bit          sector_end;
    seq_result_t tail;
    step_res.delete();
    if (it.op == asps_pkg::OP_START && eng.phase == asps_pkg::PH_IDLE) begin
      if (!present_m[it.drive]) begin
        abort(asps_pkg::FAIL_ABSENT);
      end else if (it.sector_count == '0 || it.sector_count > asps_pkg::SCNT_MAX) begin
        abort(asps_pkg::FAIL_BAD_COUNT);
      end else begin
        eng.cur_drive    = it.drive;
        eng.cur_write    = it.write_dir;
        eng.saved_lba    = it.lba;
        eng.saved_count  = it.sector_count;
        eng.sectors_left = it.sector_count;
        eng.word_index   = '0;
        eng.poll_count   = '0;
        note_reg(asps_pkg::REG_DEVICE, it.drive ? asps_pkg::DEV_SLAVE : asps_pkg::DEV_MASTER);
        note_act(asps_pkg::ACT_RD_ALT);
        eng.phase = asps_pkg::PH_SETTLE;
      end
    end else if (it.op == asps_pkg::OP_STATUS && eng.phase == asps_pkg::PH_SETTLE) begin
      // settle bytes are thrown away
      eng.word_index = eng.word_index + 8'd1;
      note_act(asps_pkg::ACT_RD_ALT);
      if (eng.word_index >= asps_pkg::SETTLE_READS) begin
        eng.word_index = '0;
        eng.poll_count = '0;
        eng.phase = asps_pkg::PH_READY;
      end
    end else if (it.op == asps_pkg::OP_STATUS && eng.phase == asps_pkg::PH_READY) begin
      bump_poll();
      if (!it.status_byte[asps_pkg::ST_BSY] && it.status_byte[asps_pkg::ST_DRDY]) begin
        note_reg(asps_pkg::REG_DEVICE, asps_pkg::DEV_LBA | {3'b000, eng.cur_drive, 4'h0}
                                       | {4'h0, eng.saved_lba[27:24]});
        note_reg(asps_pkg::REG_COUNT, eng.saved_count[7:0]);
        note_reg(asps_pkg::REG_LBA0, eng.saved_lba[7:0]);
        note_reg(asps_pkg::REG_LBA1, eng.saved_lba[15:8]);
        note_reg(asps_pkg::REG_LBA2, eng.saved_lba[23:16]);
        note_reg(asps_pkg::REG_CMD, eng.cur_write ? asps_pkg::CMD_WRITE : asps_pkg::CMD_READ);
        open_drq_wait();
      end else if (polls_used_up()) begin
        abort(asps_pkg::FAIL_READY_TO);
      end else begin
        note_act(asps_pkg::ACT_RD_ALT);
      end
    end else if (it.op == asps_pkg::OP_STATUS && eng.phase == asps_pkg::PH_DRQ) begin
      // DRQ wins over ERR
      bump_poll();
      if (it.status_byte[asps_pkg::ST_DRQ]) begin
        eng.word_index = '0;
        eng.phase = asps_pkg::PH_XFER;
        if (!eng.cur_write) note_act(asps_pkg::ACT_RD_DATA);
      end else if (it.status_byte[asps_pkg::ST_ERR]) begin
        abort(asps_pkg::FAIL_DEV_ERR);
      end else if (polls_used_up()) begin
        abort(asps_pkg::FAIL_DRQ_TO);
      end else begin
        note_act(asps_pkg::ACT_RD_STAT);
      end
    end else if (it.op == asps_pkg::OP_DATA && eng.phase == asps_pkg::PH_XFER) begin
      sector_end = (eng.word_index == asps_pkg::WORD_LAST);
      note(asps_pkg::action_t'(eng.cur_write ? asps_pkg::ACT_WR_DATA : asps_pkg::ACT_DELIVER),
           asps_pkg::REG_NONE, it.data_word, asps_pkg::FAIL_NONE);
      eng.word_index = eng.word_index + 8'd1;
      if (sector_end) begin
        eng.word_index = '0;
        if (eng.sectors_left != '0) eng.sectors_left = eng.sectors_left - 1'b1;
        if (eng.sectors_left != '0) begin
          open_drq_wait();
        end else if (eng.cur_write) begin
          note_reg(asps_pkg::REG_CMD, asps_pkg::CMD_FLUSH);
          note_act(asps_pkg::ACT_RD_ALT);
          eng.poll_count = '0;
          eng.phase = asps_pkg::PH_FLUSH;
        end else begin
          note_act(asps_pkg::ACT_DONE);
          eng.phase = asps_pkg::PH_IDLE;
        end
      end else if (!eng.cur_write) begin
        note_act(asps_pkg::ACT_RD_DATA);
      end
    end else if (it.op == asps_pkg::OP_STATUS && eng.phase == asps_pkg::PH_FLUSH) begin
      bump_poll();
      if (!it.status_byte[asps_pkg::ST_BSY]) begin
        note_act(asps_pkg::ACT_DONE);
        eng.phase = asps_pkg::PH_IDLE;
      end else if (polls_used_up()) begin
        abort(asps_pkg::FAIL_BUSY);
      end else begin
        note_act(asps_pkg::ACT_RD_ALT);
      end
    end
    if (step_res.size() > 0) begin
      tail = step_res.pop_back();
      tail.last = 1'b1;
      step_res.push_back(tail);
    end
  endfunction

  function automatic int draw_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      run_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  function automatic bus_item_t mk_op(logic [1:0] code);
    bus_item_t it;
    it.op           = code;
    it.write_dir    = 1'($urandom_range(0, 1));
    it.drive        = 1'($urandom_range(0, 1));
    it.lba          = asps_pkg::LBA_W'($urandom);
    it.sector_count = asps_pkg::SCNT_W'($urandom);
    it.status_byte  = 8'($urandom);
    it.data_word    = 16'($urandom);
    return it;
  endfunction

  function automatic bus_item_t mk_start(logic w, logic d, logic [asps_pkg::LBA_W-1:0] a,
                                         logic [asps_pkg::SCNT_W-1:0] n);
    bus_item_t it;
    it = mk_op(asps_pkg::OP_START);
    it.write_dir    = w;
    it.drive        = d;
    it.lba          = a;
    it.sector_count = n;
    return it;
  endfunction

  function automatic bus_item_t mk_status(logic [7:0] b);
    bus_item_t it;
    it = mk_op(asps_pkg::OP_STATUS);
    it.status_byte = b;
    return it;
  endfunction

  function automatic dir_row_t dir_row(row_kind_t k, bus_item_t it, asps_pkg::fail_t fc);
    dir_row_t r;
    r.kind    = k;
    r.item    = it;
    r.code    = fc;
    r.cfg_idx = '0;
    r.cfg_val = '0;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [asps_pkg::CFG_IDX_W-1:0] idx,
                                       logic [asps_pkg::CFG_DATA_W-1:0] val);
    dir_row_t r;
    r = dir_row(ROW_CONFIG, mk_op(OP_UNUSED), asps_pkg::FAIL_NONE);
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      err_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Hold the sender until every expected result has come, plus a DRAIN_PAD margin
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [asps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [asps_pkg::CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == asps_pkg::CFG_DRIVE_PRESENT) present_m = val[1:0];
    else poll_lim_m = val[asps_pkg::POLL_W-1:0];
  endtask

  task automatic offer(input bus_item_t it, input bit keep);
    int gap;
    gap = draw_gap(tx_run_left);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= it.op;
    write_dir    <= it.write_dir;
    drive        <= it.drive;
    lba          <= it.lba;
    sector_count <= it.sector_count;
    status_byte  <= it.status_byte;
    data_word    <= it.data_word;
    // sample ready between edges, then let the accepting edge pass
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    advance_engine(it);
    items_sent++;
    if (keep) foreach (step_res[i]) pending_res.push_back(step_res[i]);
  endtask

  initial begin : result_sink
    int          gap;
    bit          hold_done;
    seq_result_t want;
    hold_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(rx_run_left);
      // one long stall so the block backs up into its input
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      results_seen++;
      if (pending_res.size() == 0) begin
        err_count++;
        $error("result with no expectation: action %0d value %0d", action, value);
      end else begin
        want = pending_res.pop_front();
        check_field("action", 16'(want.action), 16'(action));
        check_field("reg_index", 16'(want.reg_index), 16'(reg_index));
        check_field("value", want.value, value);
        check_field("fail_code", 16'(want.fail_code), 16'(fail_code));
        check_field("last", 16'(want.last), 16'(last));
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    dir_row_t    rows[$];
    bus_item_t   it;
    seq_result_t typed;
    logic [1:0]  cands[$];
    int          pick;
    int          rand_items;
    bit          noise;
    bit          paused;
    logic [asps_pkg::CFG_DATA_W-1:0] lim;

    eng.phase        = asps_pkg::PH_IDLE;
    eng.cur_drive    = 1'b0;
    eng.cur_write    = 1'b0;
    eng.sectors_left = '0;
    eng.word_index   = '0;
    eng.poll_count   = '0;
    eng.saved_lba    = '0;
    eng.saved_count  = '0;
    present_m        = 2'b00;
    poll_lim_m       = asps_pkg::POLL_LIMIT_RST;
    rand_items       = 0;
    paused           = 1'b0;

    // no drive present after reset
    rows.push_back(dir_row(ROW_FAILS, mk_start(1'b0, 1'b0, '0, 9'd1),
                           asps_pkg::FAIL_ABSENT));
    rows.push_back(dir_row(ROW_IGNORED, mk_status(8'hFF), asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_IGNORED, mk_op(OP_UNUSED), asps_pkg::FAIL_NONE));
    rows.push_back(cfg_row(asps_pkg::CFG_DRIVE_PRESENT, 22'd1));
    rows.push_back(cfg_row(asps_pkg::CFG_POLL_LIMIT, 22'd0));
    rows.push_back(dir_row(ROW_FAILS, mk_start(1'b0, 1'b1, 28'h0000001, 9'd1),
                           asps_pkg::FAIL_ABSENT));
    rows.push_back(dir_row(ROW_FAILS, mk_start(1'b0, 1'b0, '0, 9'd0),
                           asps_pkg::FAIL_BAD_COUNT));
    rows.push_back(dir_row(ROW_FAILS, mk_start(1'b1, 1'b0, '0, 9'd511),
                           asps_pkg::FAIL_BAD_COUNT));
    rows.push_back(dir_row(ROW_PREDICT, mk_start(1'b1, 1'b0, 28'hFFFFFFF, 9'd256),
                           asps_pkg::FAIL_NONE));
    // start while busy
    rows.push_back(dir_row(ROW_IGNORED, mk_start(1'b0, 1'b1, '0, 9'd1), asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_PREDICT, mk_status(8'hFF), asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_PREDICT, mk_status(8'h00), asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_PREDICT, mk_status(8'h80), asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_PREDICT, mk_status(8'h7F), asps_pkg::FAIL_NONE));
    // zero poll limit still allows one poll
    rows.push_back(dir_row(ROW_FAILS, mk_status(8'h80), asps_pkg::FAIL_READY_TO));
    rows.push_back(cfg_row(asps_pkg::CFG_DRIVE_PRESENT, 22'd3));
    rows.push_back(cfg_row(asps_pkg::CFG_POLL_LIMIT, 22'h3FFFFF));
    rows.push_back(dir_row(ROW_PREDICT, mk_start(1'b0, 1'b1, 28'hA5A5A5A, 9'd256),
                           asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_PREDICT, mk_status(8'h00), asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_PREDICT, mk_status(8'hFF), asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_PREDICT, mk_status(8'h40), asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_PREDICT, mk_status(8'h08), asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_PREDICT, mk_status(8'h40), asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_FAILS, mk_status(8'h01), asps_pkg::FAIL_DEV_ERR));
    rows.push_back(dir_row(ROW_PREDICT, mk_start(1'b0, 1'b0, 28'h0123456, 9'd1),
                           asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_PREDICT, mk_status(8'h55), asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_PREDICT, mk_status(8'hAA), asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_PREDICT, mk_status(8'h0F), asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_PREDICT, mk_status(8'hF0), asps_pkg::FAIL_NONE));
    rows.push_back(dir_row(ROW_PREDICT, mk_status(8'h41), asps_pkg::FAIL_NONE));
    // DRQ and ERR together: transfer starts
    rows.push_back(dir_row(ROW_PREDICT, mk_status(8'h09), asps_pkg::FAIL_NONE));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CONFIG) begin
        write_reg(rows[i].cfg_idx, rows[i].cfg_val);
      end else begin
        offer(rows[i].item, rows[i].kind == ROW_PREDICT);
        if (rows[i].kind == ROW_FAILS) begin
          typed.action    = asps_pkg::ACT_FAIL;
          typed.reg_index = asps_pkg::REG_NONE;
          typed.value     = 16'h0000;
          typed.fail_code = rows[i].code;
          typed.last      = 1'b1;
          pending_res.push_back(typed);
        end
      end
    end

    // Random traffic shaped by the engine phase; the transfer left open above
    // is finished here
    while ((eng.phase != asps_pkg::PH_IDLE || rand_items < RAND_ITEMS)
           && rand_items < ITEM_CAP) begin
      if (eng.phase == asps_pkg::PH_IDLE && $urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 7);
        write_reg(asps_pkg::CFG_DRIVE_PRESENT,
                  (pick < 3) ? asps_pkg::CFG_DATA_W'(pick) : asps_pkg::CFG_DATA_W'(3));
        case ($urandom_range(0, 7))
          0:       lim = 22'd0;
          1:       lim = 22'd1;
          2:       lim = 22'd2;
          3:       lim = 22'd3;
          4:       lim = asps_pkg::CFG_DATA_W'($urandom_range(4, 40));
          5:       lim = 22'h3FFFFF;
          6:       lim = asps_pkg::POLL_LIMIT_RST;
          default: lim = asps_pkg::CFG_DATA_W'($urandom_range(1, 22'h3FFFFF));
        endcase
        write_reg(asps_pkg::CFG_POLL_LIMIT, lim);
      end
      // one pause in the middle of a request until all results are in
      if (!paused && rand_items >= PAUSE_AFTER && eng.phase != asps_pkg::PH_IDLE) begin
        paused = 1'b1;
        drain();
      end
      noise = ($urandom_range(0, 15) == 0);
      if (noise) begin
        cands.delete();
        cands.push_back(OP_UNUSED);
        if (eng.phase != asps_pkg::PH_IDLE) cands.push_back(asps_pkg::OP_START);
        if (eng.phase == asps_pkg::PH_IDLE || eng.phase == asps_pkg::PH_XFER)
          cands.push_back(asps_pkg::OP_STATUS);
        if (eng.phase != asps_pkg::PH_XFER) cands.push_back(asps_pkg::OP_DATA);
        it = mk_op(cands[$urandom_range(0, cands.size() - 1)]);
      end else begin
        case (eng.phase)
          asps_pkg::PH_IDLE: begin
            it = mk_op(asps_pkg::OP_START);
            pick = $urandom_range(0, 15);
            if (pick <= 11) it.sector_count = 9'd1;
            else if (pick <= 13) it.sector_count = 9'd2;
            else if (pick == 14) it.sector_count = 9'd0;
            else it.sector_count = asps_pkg::SCNT_W'($urandom_range(257, 511));
          end
          asps_pkg::PH_SETTLE: it = mk_op(asps_pkg::OP_STATUS);
          asps_pkg::PH_READY: begin
            it = mk_op(asps_pkg::OP_STATUS);
            if ($urandom_range(0, 3) != 0) begin
              it.status_byte[asps_pkg::ST_BSY]  = 1'b0;
              it.status_byte[asps_pkg::ST_DRDY] = 1'b1;
            end else if ($urandom_range(0, 1) != 0) begin
              it.status_byte[asps_pkg::ST_BSY] = 1'b1;
            end else begin
              it.status_byte[asps_pkg::ST_DRDY] = 1'b0;
            end
          end
          asps_pkg::PH_DRQ: begin
            it = mk_op(asps_pkg::OP_STATUS);
            pick = $urandom_range(0, 9);
            it.status_byte[asps_pkg::ST_DRQ] = (pick < 7);
            if (pick == 7) it.status_byte[asps_pkg::ST_ERR] = 1'b1;
            else if (pick > 7) it.status_byte[asps_pkg::ST_ERR] = 1'b0;
          end
          asps_pkg::PH_XFER: it = mk_op(asps_pkg::OP_DATA);
          default: begin
            it = mk_op(asps_pkg::OP_STATUS);
            it.status_byte[asps_pkg::ST_BSY] = ($urandom_range(0, 4) >= 3);
          end
        endcase
      end
      offer(it, 1'b1);
      if (!noise) rand_items++;
    end

    drain();
    $display("Covered %0d input items and %0d results under stalls on both sides;",
             items_sent, results_seen);
    $display("%0d requests completed, %0d ended with a failure code.", done_pred, fails_pred);
    if (err_count == 0 && pending_res.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
